FILE: hw/rtl/rmw_alu_pkg.sv
// ----------------------------------------------------------------------------
// rmw_alu_pkg
// Shared types and constants of the read-modify-write unit: operation and
// target codes, the decoded command word and the width masks.
// ----------------------------------------------------------------------------
package rmw_alu_pkg;

	typedef enum logic [2:0] {
		OP_INC = 3'd0,
		OP_DEC = 3'd1,
		OP_ASL = 3'd2,
		OP_LSR = 3'd3,
		OP_ROL = 3'd4,
		OP_ROR = 3'd5,
		OP_TRB = 3'd6,
		OP_TSB = 3'd7
	} op_t;

	typedef enum logic [1:0] {
		TGT_ACC = 2'd0,
		TGT_X   = 2'd1,
		TGT_Y   = 2'd2,
		TGT_MEM = 2'd3
	} tgt_t;

	localparam logic [15:0] NARROW_MASK = 16'h00FF;
	localparam logic [15:0] WIDE_MASK   = 16'hFFFF;
	localparam logic [15:0] NARROW_TOP  = 16'h0080;
	localparam logic [15:0] WIDE_TOP    = 16'h8000;

	// decoded word handed from the front end to the execute side
	typedef struct packed {
		op_t         op;
		tgt_t        tgt;
		logic        narrow;
		logic        invalid;
		logic [15:0] mem_value;
	} cmd_t;

endpackage

FILE: hw/rtl/rmw_alu_req_if.sv
// ----------------------------------------------------------------------------
// rmw_alu_req_if
// Request channel of the read-modify-write unit: one instruction per word.
// ----------------------------------------------------------------------------
interface rmw_alu_req_if;
	logic        valid;
	logic        ready;
	logic [2:0]  kind;
	logic [1:0]  target;
	logic        acc_narrow;
	logic        index_narrow;
	logic [15:0] mem_value;

	modport source(output valid, kind, target, acc_narrow, index_narrow, mem_value,
		input ready);
	modport sink(input valid, kind, target, acc_narrow, index_narrow, mem_value,
		output ready);
endinterface

FILE: hw/rtl/rmw_alu_rsp_if.sv
// ----------------------------------------------------------------------------
// rmw_alu_rsp_if
// Response channel of the read-modify-write unit: result value and flags.
// ----------------------------------------------------------------------------
interface rmw_alu_rsp_if;
	logic        valid;
	logic        ready;
	logic [15:0] result_value;
	logic        flag_negative;
	logic        flag_zero;
	logic        flag_carry;
	logic        invalid;

	modport source(output valid, result_value, flag_negative, flag_zero, flag_carry,
		invalid, input ready);
	modport sink(input valid, result_value, flag_negative, flag_zero, flag_carry,
		invalid, output ready);
endinterface

FILE: hw/rtl/rmw_alu_front.sv
// ----------------------------------------------------------------------------
// rmw_alu_front
// Input stage: registers the request word and decodes width, target class
// and the illegal index cases into a command word for the queue.
// ----------------------------------------------------------------------------
module rmw_alu_front (
	input  logic                clk,
	input  logic                arst_n,
	rmw_alu_req_if.sink         req,
	output logic                push_valid,
	input  logic                push_ready,
	output rmw_alu_pkg::cmd_t   push_cmd
);

	logic              valid_s1;
	rmw_alu_pkg::cmd_t cmd_s1;
	rmw_alu_pkg::cmd_t cmd_dec;
	logic              is_index;
	logic              accept;

	assign req.ready = !valid_s1 || push_ready;
	assign accept    = req.valid && req.ready;

	always_comb begin
		cmd_dec.op        = rmw_alu_pkg::op_t'(req.kind);
		cmd_dec.tgt       = rmw_alu_pkg::tgt_t'(req.target);
		is_index          = (cmd_dec.tgt == rmw_alu_pkg::TGT_X) ||
			(cmd_dec.tgt == rmw_alu_pkg::TGT_Y);
		cmd_dec.narrow    = is_index ? req.index_narrow : req.acc_narrow;
		// only inc and dec are legal on the index registers
		cmd_dec.invalid   = is_index && (cmd_dec.op != rmw_alu_pkg::OP_INC) &&
			(cmd_dec.op != rmw_alu_pkg::OP_DEC);
		cmd_dec.mem_value = req.mem_value;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (req.ready) begin
			valid_s1 <= req.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			cmd_s1 <= cmd_dec;
		end
	end

	assign push_valid = valid_s1;
	assign push_cmd   = cmd_s1;

endmodule

FILE: hw/rtl/rmw_alu_queue.sv
// ----------------------------------------------------------------------------
// rmw_alu_queue
// Small first-in first-out buffer of decoded commands between the front end
// and the execute side, with show-ahead read.
// ----------------------------------------------------------------------------
module rmw_alu_queue #(
	parameter int DEPTH = 4
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              push_valid,
	output logic              push_ready,
	input  rmw_alu_pkg::cmd_t push_cmd,
	output logic              pop_valid,
	input  logic              pop_ready,
	output rmw_alu_pkg::cmd_t pop_cmd
);

	localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W = $clog2(DEPTH + 1);

	rmw_alu_pkg::cmd_t  slot_q [DEPTH];
	logic [PTR_W-1:0]   wr_ptr_q;
	logic [PTR_W-1:0]   rd_ptr_q;
	logic [CNT_W-1:0]   count_q;
	logic               do_push;
	logic               do_pop;

	assign push_ready = (count_q != CNT_W'(DEPTH));
	assign pop_valid  = (count_q != '0);
	assign do_push    = push_valid && push_ready;
	assign do_pop     = pop_valid && pop_ready;
	assign pop_cmd    = slot_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + 1'b1;
			end else if (do_pop && !do_push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (do_push) begin
			slot_q[wr_ptr_q] <= push_cmd;
		end
	end

endmodule

FILE: hw/rtl/rmw_alu_back.sv
// ----------------------------------------------------------------------------
// rmw_alu_back
// Execute side: holds A, X, Y and the N, Z, C flags, carries out one command
// per cycle unless a response is stalled, and writes the response register.
// ----------------------------------------------------------------------------
module rmw_alu_back (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              pop_valid,
	output logic              pop_ready,
	input  rmw_alu_pkg::cmd_t pop_cmd,
	rmw_alu_rsp_if.source     rsp
);

	logic [15:0] acc_q;
	logic [15:0] x_q;
	logic [15:0] y_q;
	logic        carry_q;
	logic        neg_q;
	logic        zero_q;

	logic        rsp_valid_q;
	logic [15:0] result_q;
	logic        neg_out_q;
	logic        zero_out_q;
	logic        carry_out_q;
	logic        invalid_q;

	logic [15:0] opnd;
	logic [15:0] mask;
	logic [15:0] top;
	logic [15:0] v;
	logic [15:0] a;
	logic [15:0] r_raw;
	logic [15:0] r;
	logic [15:0] full;
	logic        v_msb;
	logic        bitop;
	logic        neg_nxt;
	logic        zero_nxt;
	logic        carry_nxt;
	logic        fire;

	assign pop_ready = !rsp_valid_q || rsp.ready;
	assign fire      = pop_valid && pop_ready;

	always_comb begin
		case (pop_cmd.tgt)
			rmw_alu_pkg::TGT_ACC: opnd = acc_q;
			rmw_alu_pkg::TGT_X:   opnd = x_q;
			rmw_alu_pkg::TGT_Y:   opnd = y_q;
			default:              opnd = pop_cmd.mem_value;
		endcase

		mask      = pop_cmd.narrow ? rmw_alu_pkg::NARROW_MASK : rmw_alu_pkg::WIDE_MASK;
		top       = pop_cmd.narrow ? rmw_alu_pkg::NARROW_TOP : rmw_alu_pkg::WIDE_TOP;
		v         = opnd & mask;
		a         = acc_q & mask;
		v_msb     = |(v & top);
		bitop     = 1'b0;
		carry_nxt = carry_q;

		unique case (pop_cmd.op)
			rmw_alu_pkg::OP_INC: r_raw = v + 16'd1;
			rmw_alu_pkg::OP_DEC: r_raw = v - 16'd1;
			rmw_alu_pkg::OP_ASL: begin
				r_raw     = v << 1;
				carry_nxt = v_msb;
			end
			rmw_alu_pkg::OP_LSR: begin
				r_raw     = v >> 1;
				carry_nxt = v[0];
			end
			rmw_alu_pkg::OP_ROL: begin
				r_raw     = (v << 1) | {15'd0, carry_q};
				carry_nxt = v_msb;
			end
			rmw_alu_pkg::OP_ROR: begin
				r_raw     = (v >> 1) | (carry_q ? top : 16'd0);
				carry_nxt = v[0];
			end
			rmw_alu_pkg::OP_TRB: begin
				r_raw = v & ~a;
				bitop = 1'b1;
			end
			rmw_alu_pkg::OP_TSB: begin
				r_raw = v | a;
				bitop = 1'b1;
			end
		endcase

		r = r_raw & mask;

		// bit tests set zero from the and with the accumulator, keep negative
		if (bitop) begin
			neg_nxt  = neg_q;
			zero_nxt = ((v & a) == 16'd0);
		end else begin
			neg_nxt  = |(r & top);
			zero_nxt = (r == 16'd0);
		end

		full = (opnd & ~mask) | r;

		// illegal index operation: nothing changes, report current state
		if (pop_cmd.invalid) begin
			full      = opnd;
			neg_nxt   = neg_q;
			zero_nxt  = zero_q;
			carry_nxt = carry_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			acc_q   <= '0;
			x_q     <= '0;
			y_q     <= '0;
			carry_q <= 1'b0;
			neg_q   <= 1'b0;
			zero_q  <= 1'b0;
		end else if (fire && !pop_cmd.invalid) begin
			carry_q <= carry_nxt;
			neg_q   <= neg_nxt;
			zero_q  <= zero_nxt;
			case (pop_cmd.tgt)
				rmw_alu_pkg::TGT_ACC: acc_q <= full;
				rmw_alu_pkg::TGT_X:   x_q   <= full;
				rmw_alu_pkg::TGT_Y:   y_q   <= full;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (pop_ready) begin
			rsp_valid_q <= pop_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (fire) begin
			result_q    <= full;
			neg_out_q   <= neg_nxt;
			zero_out_q  <= zero_nxt;
			carry_out_q <= carry_nxt;
			invalid_q   <= pop_cmd.invalid;
		end
	end

	assign rsp.valid         = rsp_valid_q;
	assign rsp.result_value  = result_q;
	assign rsp.flag_negative = neg_out_q;
	assign rsp.flag_zero     = zero_out_q;
	assign rsp.flag_carry    = carry_out_q;
	assign rsp.invalid       = invalid_q;

endmodule

FILE: hw/rtl/cpu_read_modify_write_alu.sv
// ----------------------------------------------------------------------------
// cpu_read_modify_write_alu
// Read-modify-write unit with its own A, X, Y and N, Z, C state.
// ----------------------------------------------------------------------------
// Takes one instruction word per clock while the input register can pass
// its word on, and returns one response word per instruction, in order. A
// word passes through the input register, the command queue and the execute
// stage that fills the response register. The execute stage handles one word
// per cycle while the response register is free or being taken; it reads and
// updates the register file in the same cycle so that the next instruction
// sees the new value at once. QUEUE_DEPTH sets how many decoded words can
// wait while the response side is stalled.
module cpu_read_modify_write_alu #(
	parameter int QUEUE_DEPTH = 4
) (
	input  logic          clk,
	input  logic          arst_n,
	rmw_alu_req_if.sink   req,
	rmw_alu_rsp_if.source rsp
);

	logic              push_valid;
	logic              push_ready;
	rmw_alu_pkg::cmd_t push_cmd;
	logic              pop_valid;
	logic              pop_ready;
	rmw_alu_pkg::cmd_t pop_cmd;

	rmw_alu_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.req        (req),
		.push_valid (push_valid),
		.push_ready (push_ready),
		.push_cmd   (push_cmd)
	);

	rmw_alu_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push_valid (push_valid),
		.push_ready (push_ready),
		.push_cmd   (push_cmd),
		.pop_valid  (pop_valid),
		.pop_ready  (pop_ready),
		.pop_cmd    (pop_cmd)
	);

	rmw_alu_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.pop_valid (pop_valid),
		.pop_ready (pop_ready),
		.pop_cmd   (pop_cmd),
		.rsp       (rsp)
	);

endmodule

FILE: hw/rtl/rmw_alu_checker.sv
// ----------------------------------------------------------------------------
// rmw_alu_checker
// Port-level checks of the read-modify-write unit, bound to the top level.
// ----------------------------------------------------------------------------
module rmw_alu_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        req_valid,
	input logic        req_ready,
	input logic        rsp_valid,
	input logic        rsp_ready,
	input logic [15:0] rsp_result_value,
	input logic        rsp_flag_negative,
	input logic        rsp_flag_zero,
	input logic        rsp_flag_carry,
	input logic        rsp_invalid
);

	logic [7:0] pending_q;
	logic [2:0] flags_q;
	logic       req_fire;
	logic       rsp_fire;

	assign req_fire = req_valid && req_ready;
	assign rsp_fire = rsp_valid && rsp_ready;

	// words in flight and the flags of the last delivered word
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pending_q <= '0;
			flags_q   <= '0;
		end else begin
			if (req_fire && !rsp_fire) begin
				pending_q <= pending_q + 8'd1;
			end else if (rsp_fire && !req_fire) begin
				pending_q <= pending_q - 8'd1;
			end
			if (rsp_fire) begin
				flags_q <= {rsp_flag_negative, rsp_flag_zero, rsp_flag_carry};
			end
		end
	end

	a_rsp_valid_holds: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp_ready |=> rsp_valid)
		else $error("response valid dropped while stalled");

	a_rsp_payload_holds: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp_ready |=> $stable(rsp_result_value) && $stable(rsp_invalid))
		else $error("response word changed while stalled");

	a_no_spurious_rsp: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid |-> pending_q != 8'd0)
		else $error("response without an outstanding request");

	a_invalid_keeps_flags: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_fire && rsp_invalid |->
			{rsp_flag_negative, rsp_flag_zero, rsp_flag_carry} == flags_q)
		else $error("illegal operation changed the flags");

endmodule

bind cpu_read_modify_write_alu rmw_alu_checker u_rmw_alu_checker (
	.clk               (clk),
	.arst_n            (arst_n),
	.req_valid         (req.valid),
	.req_ready         (req.ready),
	.rsp_valid         (rsp.valid),
	.rsp_ready         (rsp.ready),
	.rsp_result_value  (rsp.result_value),
	.rsp_flag_negative (rsp.flag_negative),
	.rsp_flag_zero     (rsp.flag_zero),
	.rsp_flag_carry    (rsp.flag_carry),
	.rsp_invalid       (rsp.invalid)
);

FILE: test/tb_cpu_read_modify_write_alu.sv
// ----------------------------------------------------------------------------
// tb_cpu_read_modify_write_alu
// Self-checking bench for the read-modify-write unit. A scoreboard keeps its
// own A, X, Y and N, Z, C copy, predicts the response to every instruction
// word taken by the block and compares each response word in order. Directed
// words cover width wrap, carry in and out, the bit tests and the illegal
// index operations. Random words with idle bursts on both channels follow.
// ----------------------------------------------------------------------------
module tb_cpu_read_modify_write_alu;

	localparam int RANDOM_WORDS = 1425;
	localparam int CALM_WORDS   = 200;
	localparam int QUIET_LIMIT  = 400;

	typedef struct packed {
		logic [15:0] value;
		logic        neg;
		logic        zer;
		logic        carry;
		logic        inv;
	} rmw_result_t;

	class rmw_scoreboard;
		logic [15:0]  acc;
		logic [15:0]  idx_x;
		logic [15:0]  idx_y;
		logic         carry;
		logic         neg;
		logic         zer;
		rmw_result_t  expected_q[$];
		int           errors;

		function new();
			acc    = '0;
			idx_x  = '0;
			idx_y  = '0;
			carry  = 1'b0;
			neg    = 1'b0;
			zer    = 1'b0;
			errors = 0;
		endfunction

		function int pending();
			return expected_q.size();
		endfunction

		// work out the response of one instruction and update the register copy
		function void note_word(rmw_alu_pkg::op_t op, rmw_alu_pkg::tgt_t tgt, logic acc_n,
			logic idx_n, logic [15:0] mem);
			logic        is_index;
			logic        bitop;
			logic        cin;
			logic [15:0] mask;
			logic [15:0] top;
			logic [15:0] opnd;
			logic [15:0] v;
			logic [15:0] a;
			logic [15:0] r;
			logic [15:0] full;
			is_index = (tgt == rmw_alu_pkg::TGT_X) || (tgt == rmw_alu_pkg::TGT_Y);
			mask = (is_index ? idx_n : acc_n) ? rmw_alu_pkg::NARROW_MASK :
				rmw_alu_pkg::WIDE_MASK;
			top  = (is_index ? idx_n : acc_n) ? rmw_alu_pkg::NARROW_TOP :
				rmw_alu_pkg::WIDE_TOP;
			case (tgt)
				rmw_alu_pkg::TGT_ACC: opnd = acc;
				rmw_alu_pkg::TGT_X:   opnd = idx_x;
				rmw_alu_pkg::TGT_Y:   opnd = idx_y;
				default:              opnd = mem;
			endcase
			// only inc and dec are legal on an index register
			if (is_index && op != rmw_alu_pkg::OP_INC && op != rmw_alu_pkg::OP_DEC) begin
				expected_q.push_back('{opnd, neg, zer, carry, 1'b1});
				return;
			end
			v     = opnd & mask;
			a     = acc & mask;
			bitop = 1'b0;
			cin   = carry;
			r     = '0;
			case (op)
				rmw_alu_pkg::OP_INC: r = v + 16'd1;
				rmw_alu_pkg::OP_DEC: r = v + mask;
				rmw_alu_pkg::OP_ASL: begin
					carry = |(v & top);
					r     = v << 1;
				end
				rmw_alu_pkg::OP_LSR: begin
					carry = v[0];
					r     = v >> 1;
				end
				rmw_alu_pkg::OP_ROL: begin
					carry = |(v & top);
					r     = (v << 1) | {15'd0, cin};
				end
				rmw_alu_pkg::OP_ROR: begin
					carry = v[0];
					r     = (v >> 1) | (cin ? top : 16'd0);
				end
				rmw_alu_pkg::OP_TRB: begin
					bitop = 1'b1;
					zer   = ((v & a) == 16'd0);
					r     = v & ~a;
				end
				default: begin
					bitop = 1'b1;
					zer   = ((v & a) == 16'd0);
					r     = v | a;
				end
			endcase
			r = r & mask;
			if (!bitop) begin
				neg = |(r & top);
				zer = (r == 16'd0);
			end
			// narrow mode keeps the high byte of the operand
			full = (opnd & ~mask) | r;
			case (tgt)
				rmw_alu_pkg::TGT_ACC: acc = full;
				rmw_alu_pkg::TGT_X:   idx_x = full;
				rmw_alu_pkg::TGT_Y:   idx_y = full;
				default: ;
			endcase
			expected_q.push_back('{full, neg, zer, carry, 1'b0});
		endfunction

		function void report(string field, logic [15:0] want, logic [15:0] got);
			errors++;
			$display("%0t mismatch %s: expected %h, actual %h", $time, field, want, got);
		endfunction

		function void check_word(rmw_result_t got);
			rmw_result_t want;
			if (expected_q.size() == 0) begin
				errors++;
				$display("%0t unexpected response word: expected none, actual %h",
					$time, got);
				return;
			end
			want = expected_q.pop_front();
			if (got.value !== want.value)
				report("result_value", want.value, got.value);
			if (got.neg !== want.neg)
				report("flag_negative", {15'd0, want.neg}, {15'd0, got.neg});
			if (got.zer !== want.zer)
				report("flag_zero", {15'd0, want.zer}, {15'd0, got.zer});
			if (got.carry !== want.carry)
				report("flag_carry", {15'd0, want.carry}, {15'd0, got.carry});
			if (got.inv !== want.inv)
				report("invalid", {15'd0, want.inv}, {15'd0, got.inv});
		endfunction
	endclass

	logic          clk;
	logic          arst_n;
	bit            idle_on;
	int            quiet;
	rmw_scoreboard sb;

	rmw_alu_req_if req();
	rmw_alu_rsp_if rsp();

	cpu_read_modify_write_alu dut (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req.sink),
		.rsp    (rsp.source)
	);

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	// called at a falling edge, returns at the falling edge after acceptance
	task automatic send_word(rmw_alu_pkg::op_t op, rmw_alu_pkg::tgt_t tgt, logic acc_n,
		logic idx_n, logic [15:0] mem);
		if (idle_on && $urandom_range(0, 5) == 0) begin
			req.valid <= 1'b0;
			repeat ($urandom_range(1, 18)) @(negedge clk);
		end
		req.valid        <= 1'b1;
		req.kind         <= op;
		req.target       <= tgt;
		req.acc_narrow   <= acc_n;
		req.index_narrow <= idx_n;
		req.mem_value    <= mem;
		@(posedge clk);
		while (!req.ready) @(posedge clk);
		@(negedge clk);
	endtask

	// response side back-pressure
	initial begin
		rsp.ready = 1'b0;
		forever begin
			@(negedge clk);
			if (idle_on && $urandom_range(0, 5) == 0) begin
				rsp.ready <= 1'b0;
				repeat ($urandom_range(1, 18) - 1) @(negedge clk);
			end else begin
				rsp.ready <= 1'b1;
			end
		end
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if (req.valid && req.ready)
				sb.note_word(rmw_alu_pkg::op_t'(req.kind), rmw_alu_pkg::tgt_t'(req.target),
					req.acc_narrow, req.index_narrow, req.mem_value);
			if (rsp.valid && rsp.ready)
				sb.check_word('{rsp.result_value, rsp.flag_negative, rsp.flag_zero,
					rsp.flag_carry, rsp.invalid});
		end
	end

	// cycles with no word moving on either channel
	initial begin
		quiet = 0;
		while (quiet < QUIET_LIMIT) begin
			@(posedge clk);
			if ((req.valid && req.ready) || (rsp.valid && rsp.ready))
				quiet = 0;
			else
				quiet++;
		end
		$display("[FAIL] regression broken");
		$finish;
	end

	initial begin
		rmw_alu_pkg::op_t  op;
		rmw_alu_pkg::tgt_t tgt;
		logic              acc_n;
		logic              idx_n;
		logic [15:0]       mem;
		clk              = 1'b0;
		arst_n           = 1'b0;
		idle_on          = 1'b1;
		req.valid        = 1'b0;
		req.kind         = '0;
		req.target       = '0;
		req.acc_narrow   = 1'b0;
		req.index_narrow = 1'b0;
		req.mem_value    = '0;
		sb = new();
		repeat (5) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// accumulator wrap at both widths, high byte kept in narrow mode
		send_word(rmw_alu_pkg::OP_INC, rmw_alu_pkg::TGT_ACC, 1'b0, 1'b0, 16'h0000);
		send_word(rmw_alu_pkg::OP_DEC, rmw_alu_pkg::TGT_ACC, 1'b0, 1'b0, 16'h0000);
		send_word(rmw_alu_pkg::OP_DEC, rmw_alu_pkg::TGT_ACC, 1'b0, 1'b0, 16'h0000);
		send_word(rmw_alu_pkg::OP_INC, rmw_alu_pkg::TGT_ACC, 1'b1, 1'b0, 16'h0000);
		send_word(rmw_alu_pkg::OP_INC, rmw_alu_pkg::TGT_ACC, 1'b0, 1'b1, 16'hFFFF);
		send_word(rmw_alu_pkg::OP_ASL, rmw_alu_pkg::TGT_ACC, 1'b0, 1'b0, 16'h0000);
		send_word(rmw_alu_pkg::OP_ROL, rmw_alu_pkg::TGT_ACC, 1'b1, 1'b0, 16'h0000);
		// memory shifts and rotates with carry in and out
		send_word(rmw_alu_pkg::OP_LSR, rmw_alu_pkg::TGT_MEM, 1'b0, 1'b0, 16'h0001);
		send_word(rmw_alu_pkg::OP_ROR, rmw_alu_pkg::TGT_MEM, 1'b0, 1'b0, 16'h0000);
		send_word(rmw_alu_pkg::OP_ROR, rmw_alu_pkg::TGT_MEM, 1'b1, 1'b0, 16'hAB01);
		send_word(rmw_alu_pkg::OP_ROL, rmw_alu_pkg::TGT_MEM, 1'b0, 1'b0, 16'hFFFF);
		send_word(rmw_alu_pkg::OP_ASL, rmw_alu_pkg::TGT_MEM, 1'b1, 1'b1, 16'h7F80);
		// bit tests, including the accumulator as its own mask
		send_word(rmw_alu_pkg::OP_TRB, rmw_alu_pkg::TGT_MEM, 1'b0, 1'b0, 16'hFFFF);
		send_word(rmw_alu_pkg::OP_TSB, rmw_alu_pkg::TGT_MEM, 1'b1, 1'b0, 16'h0000);
		send_word(rmw_alu_pkg::OP_TSB, rmw_alu_pkg::TGT_ACC, 1'b0, 1'b0, 16'h5A5A);
		send_word(rmw_alu_pkg::OP_TRB, rmw_alu_pkg::TGT_ACC, 1'b1, 1'b0, 16'h0000);
		send_word(rmw_alu_pkg::OP_TRB, rmw_alu_pkg::TGT_ACC, 1'b0, 1'b0, 16'h0000);
		// index inc and dec at both widths
		send_word(rmw_alu_pkg::OP_INC, rmw_alu_pkg::TGT_X, 1'b0, 1'b1, 16'hFFFF);
		send_word(rmw_alu_pkg::OP_DEC, rmw_alu_pkg::TGT_Y, 1'b1, 1'b0, 16'h0000);
		send_word(rmw_alu_pkg::OP_DEC, rmw_alu_pkg::TGT_Y, 1'b0, 1'b1, 16'h0000);
		send_word(rmw_alu_pkg::OP_INC, rmw_alu_pkg::TGT_X, 1'b1, 1'b0, 16'h0000);
		// illegal operations on X and Y leave everything alone
		for (int k = rmw_alu_pkg::OP_ASL; k <= rmw_alu_pkg::OP_TSB; k++)
			send_word(rmw_alu_pkg::op_t'(k),
				(k[0] == 1'b0) ? rmw_alu_pkg::TGT_X : rmw_alu_pkg::TGT_Y,
				k[0], k[1], 16'hFFFF);

		for (int n = 0; n < RANDOM_WORDS; n++) begin
			if (n == RANDOM_WORDS / 3) begin
				// let the pipeline drain completely before carrying on
				req.valid <= 1'b0;
				do @(negedge clk); while (sb.pending() != 0);
			end
			if (n == RANDOM_WORDS - CALM_WORDS)
				idle_on = 1'b0;
			op    = rmw_alu_pkg::op_t'(3'($urandom_range(0, 7)));
			tgt   = rmw_alu_pkg::tgt_t'(2'($urandom_range(0, 3)));
			acc_n = 1'($urandom_range(0, 1));
			idx_n = 1'($urandom_range(0, 1));
			case ($urandom_range(0, 9))
				0:       mem = 16'h0000;
				1:       mem = 16'hFFFF;
				2:       mem = 16'h8000;
				3:       mem = 16'h0080;
				4:       mem = {8'($urandom_range(0, 255)), 8'hFF};
				5:       mem = {8'($urandom_range(0, 255)), 8'h00};
				default: mem = 16'($urandom_range(0, 65535));
			endcase
			send_word(op, tgt, acc_n, idx_n, mem);
		end
		req.valid <= 1'b0;

		while (sb.pending() != 0) @(negedge clk);
		repeat (8) @(negedge clk);
		if (sb.errors == 0)
			$display("[ OK ] regression clean");
		else
			$display("[FAIL] regression broken");
		$finish;
	end

endmodule

FILE: sim.f
hw/rtl/rmw_alu_pkg.sv
hw/rtl/rmw_alu_req_if.sv
hw/rtl/rmw_alu_rsp_if.sv
hw/rtl/rmw_alu_front.sv
hw/rtl/rmw_alu_queue.sv
hw/rtl/rmw_alu_back.sv
hw/rtl/cpu_read_modify_write_alu.sv
hw/rtl/rmw_alu_checker.sv
test/tb_cpu_read_modify_write_alu.sv
